FILE: hw/rtl/cau_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared opcodes and width defaults for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DataWidthDefault = 32;
   localparam int FracBitsDefault  = 16;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

endpackage : cau_pkg
`default_nettype wire

FILE: hw/rtl/cau_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div_pipe
// Pipelined unsigned restoring divider. One quotient bit is resolved per stage,
// so a new numerator/denominator pair enters on every cycle that en is high.
// A shared enable advances every stage at once; with it low, every stage holds.
// ----------------------------------------------------------------------------
module cau_div_pipe #(
   parameter int NumWidth = 96,
   parameter int DenWidth = 64
) (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic [NumWidth-1:0] num,
   input  wire logic [DenWidth-1:0] den,
   output logic      [NumWidth-1:0] quo
);
   localparam int RemWidth = DenWidth + 1;

   // Stage registers; the last stage keeps only its quotient
   logic [NumWidth-1:0] q_ff [NumWidth];
   logic [NumWidth-1:0] n_ff [NumWidth-1];
   logic [RemWidth-1:0] r_ff [NumWidth-1];
   logic [DenWidth-1:0] d_ff [NumWidth-1];

   // One quotient bit per stage, most significant first
   for (genvar s = 0; s < NumWidth; s++) begin : g_stage
      logic [NumWidth-1:0] n_cur;
      logic [NumWidth-1:0] q_cur;
      logic [RemWidth-1:0] r_cur;
      logic [DenWidth-1:0] d_cur;
      logic [RemWidth:0]   trial;
      logic [RemWidth:0]   diff;

      // Take the operands from the ports or from the stage before
      if (s == 0) begin : g_load
         assign n_cur = num;
         assign q_cur = '0;
         assign r_cur = '0;
         assign d_cur = den;
      end else begin : g_chain
         assign n_cur = n_ff[s-1];
         assign q_cur = q_ff[s-1];
         assign r_cur = r_ff[s-1];
         assign d_cur = d_ff[s-1];
      end

      assign trial = {r_cur, n_cur[NumWidth-1]};
      assign diff  = trial - {2'b00, d_cur};

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[s] <= {q_cur[NumWidth-2:0], !diff[RemWidth]};
         end
      end

      // Advance the numerator, divisor and partial remainder
      if (s < NumWidth - 1) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               n_ff[s] <= n_cur << 1;
               d_ff[s] <= d_cur;
               if (!diff[RemWidth]) begin
                  r_ff[s] <= diff[RemWidth-1:0];
               end else begin
                  r_ff[s] <= trial[RemWidth-1:0];
               end
            end
         end
      end
   end

   assign quo = q_ff[NumWidth-1];
endmodule : cau_div_pipe
`default_nettype wire

FILE: hw/rtl/complex_arithmetic_unit_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Complex add, subtract, multiply and divide on signed Q(DATA_WIDTH-FRAC_BITS).
// FRAC_BITS operands with saturated results and overflow / divide-by-zero flags.
//
// Usage: present opcode and both operands on the req_ channel; one result beat
// per request leaves on the rsp_ channel in request order. All operations share
// one pipeline so that results never reorder.
// The request path runs through four front stages, the bit-per-stage divider
// (2*DATA_WIDTH+1+FRAC_BITS stages) and the output register; the add, subtract
// and multiply paths are delayed to match. Throughput: one beat per cycle while
// the output is not stalled.
// The whole pipeline advances together; when rsp_ready is low with a result
// waiting, every stage holds and req_ready drops. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = cau_pkg::DataWidthDefault,
   parameter int FRAC_BITS  = cau_pkg::FracBitsDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [DATA_WIDTH-1:0] req_a_re,
   input  wire logic [DATA_WIDTH-1:0] req_a_im,
   input  wire logic [DATA_WIDTH-1:0] req_b_re,
   input  wire logic [DATA_WIDTH-1:0] req_b_im,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0]      rsp_res_re,
   output logic [DATA_WIDTH-1:0]      rsp_res_im,
   output logic                       rsp_overflow,
   output logic                       rsp_div_zero
);
   localparam int W   = DATA_WIDTH;
   localparam int PW  = 2 * W;          // product width
   localparam int SW  = PW + 1;         // sum of two products
   localparam int NW  = SW + FRAC_BITS; // divider numerator
   localparam int DLY = NW;             // divider latency
   localparam logic [NW-1:0] MAXP = (NW'(1) << (W - 1)) - NW'(1);

   typedef struct packed {
      logic          neg;
      logic [NW-1:0] mag;
   } sres_type;

   typedef struct packed {
      logic             is_div;
      logic             dz;
   } ctl_type;

   logic en;

   // ---------------- stage 1: register inputs --------------------------------
   logic             v1_ff;
   logic [1:0]       op1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   // ---------------- stage 2: four products, denominator squares -----------
   logic             v2_ff;
   logic [1:0]       op2_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ir_ff, p_ri_ff;
   logic [PW-1:0]   sq_r_ff, sq_i_ff;
   logic signed [W:0] s_re_ff, s_im_ff;

   // ---------------- stage 3: combine ----------------------------------------
   logic             v3_ff;
   logic [1:0]       op3_ff;
   logic signed [SW-1:0] c_re_ff, c_im_ff;
   logic [PW:0]      den3_ff;

   // ---------------- stage 4: magnitude / rounding --------------------------
   logic             v4_ff;
   ctl_type          ctl4_ff;
   sres_type         m_re4_ff, m_im4_ff;
   logic [PW:0]      den4_ff;

   // delay line matching divider
   logic             vd_ff  [DLY];
   ctl_type          ctld_ff[DLY];
   sres_type         mre_d_ff[DLY];
   sres_type         mim_d_ff[DLY];

   logic [NW-1:0]    quo_re, quo_im;

   // output register
   logic             v_out_ff;
   logic [W-1:0]     re_out_ff, im_out_ff;
   logic             ov_out_ff, dz_out_ff;

   // Advance everything when the last stage is empty or being taken
   assign en        = !v_out_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff <= req_opcode;
         ar1_ff <= req_a_re;
         ai1_ff <= req_a_im;
         br1_ff <= req_b_re;
         bi1_ff <= req_b_im;
      end
   end

   // Products and plain sums
   always_ff @(posedge clock) begin
      if (en) begin
         op2_ff  <= op1_ff;
         p_rr_ff <= PW'(ar1_ff * br1_ff);
         p_ii_ff <= PW'(ai1_ff * bi1_ff);
         p_ir_ff <= PW'(ai1_ff * br1_ff);
         p_ri_ff <= PW'(ar1_ff * bi1_ff);
         sq_r_ff <= PW'(br1_ff * br1_ff);
         sq_i_ff <= PW'(bi1_ff * bi1_ff);
         if (op1_ff == OP_SUB) begin
            s_re_ff <= {ar1_ff[W-1], ar1_ff} - {br1_ff[W-1], br1_ff};
            s_im_ff <= {ai1_ff[W-1], ai1_ff} - {bi1_ff[W-1], bi1_ff};
         end else begin
            s_re_ff <= {ar1_ff[W-1], ar1_ff} + {br1_ff[W-1], br1_ff};
            s_im_ff <= {ai1_ff[W-1], ai1_ff} + {bi1_ff[W-1], bi1_ff};
         end
      end
   end

   // Combine products per opcode
   always_ff @(posedge clock) begin
      if (en) begin
         op3_ff  <= op2_ff;
         den3_ff <= {1'b0, sq_r_ff} + {1'b0, sq_i_ff};
         case (op2_ff)
            OP_MUL: begin
               c_re_ff <= SW'(p_rr_ff) - SW'(p_ii_ff);
               c_im_ff <= SW'(p_ir_ff) + SW'(p_ri_ff);
            end
            OP_DIV: begin
               c_re_ff <= SW'(p_rr_ff) + SW'(p_ii_ff);
               c_im_ff <= SW'(p_ir_ff) - SW'(p_ri_ff);
            end
            default: begin
               c_re_ff <= SW'(s_re_ff);
               c_im_ff <= SW'(s_im_ff);
            end
         endcase
      end
   end

   // Sign/magnitude split; round the product (ties away from zero)
   function automatic sres_type to_mag(input logic signed [SW-1:0] x,
                                       input logic do_round, input logic do_shift);
      sres_type   r;
      logic [SW-1:0] m;
      logic [NW-1:0] t;
      begin
         m = x[SW-1] ? SW'(-x) : SW'(x);
         r.neg = x[SW-1];
         t = NW'(m);
         if (do_round && FRAC_BITS > 0) begin
            t = (t + (NW'(1) << FRAC_BITS) / 2) >> FRAC_BITS;
         end
         if (do_shift) begin
            t = t << FRAC_BITS;
         end
         r.mag = t;
         return r;
      end
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         ctl4_ff.is_div <= (op3_ff == OP_DIV);
         ctl4_ff.dz     <= (op3_ff == OP_DIV) && (den3_ff == '0);
         m_re4_ff <= to_mag(c_re_ff, op3_ff == OP_MUL, op3_ff == OP_DIV);
         m_im4_ff <= to_mag(c_im_ff, op3_ff == OP_MUL, op3_ff == OP_DIV);
         den4_ff  <= den3_ff;
      end
   end

   cau_div_pipe #(.NumWidth(NW), .DenWidth(PW + 1)) u_div_re (
      .clock(clock), .en(en), .num(m_re4_ff.mag), .den(den4_ff), .quo(quo_re)
   );
   cau_div_pipe #(.NumWidth(NW), .DenWidth(PW + 1)) u_div_im (
      .clock(clock), .en(en), .num(m_im4_ff.mag), .den(den4_ff), .quo(quo_im)
   );

   // Carry control and non-divide results alongside the divider
   always_ff @(posedge clock) begin
      if (en) begin
         ctld_ff[0]  <= ctl4_ff;
         mre_d_ff[0] <= m_re4_ff;
         mim_d_ff[0] <= m_im4_ff;
         for (int k = 1; k < DLY; k++) begin
            ctld_ff[k]  <= ctld_ff[k-1];
            mre_d_ff[k] <= mre_d_ff[k-1];
            mim_d_ff[k] <= mim_d_ff[k-1];
         end
      end
   end

   function automatic logic [W:0] sat(input logic neg, input logic [NW-1:0] m);
      logic [NW-1:0] lim;
      logic [W-1:0]  v;
      logic          ov;
      begin
         lim = neg ? MAXP + NW'(1) : MAXP;
         ov  = (m > lim);
         v   = ov ? W'(lim) : W'(m);
         return {ov, neg ? W'(-v) : v};
      end
   endfunction

   logic [W:0] sre, sim;
   ctl_type    ctl_l;
   assign ctl_l = ctld_ff[DLY-1];
   assign sre = sat(mre_d_ff[DLY-1].neg,
                    ctl_l.is_div ? quo_re : mre_d_ff[DLY-1].mag);
   assign sim = sat(mim_d_ff[DLY-1].neg,
                    ctl_l.is_div ? quo_im : mim_d_ff[DLY-1].mag);

   always_ff @(posedge clock) begin
      if (en) begin
         if (ctl_l.dz) begin
            re_out_ff <= '0;
            im_out_ff <= '0;
            ov_out_ff <= 1'b0;
            dz_out_ff <= 1'b1;
         end else begin
            re_out_ff <= sre[W-1:0];
            im_out_ff <= sim[W-1:0];
            ov_out_ff <= sre[W] | sim[W];
            dz_out_ff <= 1'b0;
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v_out_ff <= 1'b0;
         for (int k = 0; k < DLY; k++) vd_ff[k] <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vd_ff[0] <= v4_ff;
         for (int k = 1; k < DLY; k++) vd_ff[k] <= vd_ff[k-1];
         v_out_ff <= vd_ff[DLY-1];
      end
   end

   assign rsp_valid    = v_out_ff;
   assign rsp_res_re   = re_out_ff;
   assign rsp_res_im   = im_out_ff;
   assign rsp_overflow = ov_out_ff;
   assign rsp_div_zero = dz_out_ff;

   // Flags never both set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_overflow && rsp_div_zero))
      else $error("overflow and div_zero both set");
   // Divide by zero result is zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_zero) |-> (rsp_res_re == '0 && rsp_res_im == '0))
      else $error("divide by zero result not zero");
   // Stall holds the pipeline
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_res_re)))
      else $error("result changed under stall");
endmodule : complex_arithmetic_unit_core
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the complex add / subtract / multiply / divide core.
// Drives request beats under varying idle and stall ratios, predicts each
// Q16.16 result with exact wide arithmetic, and checks the results in order.
// ----------------------------------------------------------------------------
module tb;
   import cau_pkg::*;

   localparam int DW        = 32;
   localparam int FB        = 16;
   localparam int LATENCY   = 6 + 2 * DW + FB;
   localparam int CYCLE_CAP = 400000;

   typedef struct packed {
      opcode_type      opcode;
      logic [DW-1:0]   a_re;
      logic [DW-1:0]   a_im;
      logic [DW-1:0]   b_re;
      logic [DW-1:0]   b_im;
   } cplx_request_type;

   typedef struct packed {
      logic [DW-1:0]   res_re;
      logic [DW-1:0]   res_im;
      logic            overflow;
      logic            div_zero;
   } cplx_result_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [1:0]      req_opcode = '0;
   logic [DW-1:0]   req_a_re = '0;
   logic [DW-1:0]   req_a_im = '0;
   logic [DW-1:0]   req_b_re = '0;
   logic [DW-1:0]   req_b_im = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [DW-1:0]   rsp_res_re;
   logic [DW-1:0]   rsp_res_im;
   logic            rsp_overflow;
   logic            rsp_div_zero;

   cplx_result_type pending_results[$];
   int              mismatch_count = 0;
   int              send_idle_pct  = 0;
   int              rsp_stall_pct  = 0;
   bit              rsp_hold       = 1'b0;
   int              cycle_count    = 0;

   complex_arithmetic_unit_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_a_re     (req_a_re),
      .req_a_im     (req_a_im),
      .req_b_re     (req_b_re),
      .req_b_im     (req_b_im),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_res_re   (rsp_res_re),
      .rsp_res_im   (rsp_res_im),
      .rsp_overflow (rsp_overflow),
      .rsp_div_zero (rsp_div_zero)
   );

   always #10 clock = ~clock;

   // Abort on a runaway run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("FAIL complex_arithmetic_unit_core");
         $finish;
      end
   end

   // Clamp an exact signed value to the Q16.16 range, flag any clamping
   function automatic logic [DW-1:0] clamp_q(input logic signed [127:0] x,
                                             inout logic ov);
      logic signed [127:0] hi_lim;
      logic signed [127:0] lo_lim;
      hi_lim = (128'sd1 <<< (DW - 1)) - 128'sd1;
      lo_lim = -(128'sd1 <<< (DW - 1));
      if (x > hi_lim) begin
         ov = 1'b1;
         return hi_lim[DW-1:0];
      end
      if (x < lo_lim) begin
         ov = 1'b1;
         return lo_lim[DW-1:0];
      end
      return x[DW-1:0];
   endfunction

   // Drop fraction bits of a product, nearest with ties away from zero
   function automatic logic signed [127:0] round_product(input logic signed [127:0] x);
      logic [127:0] m;
      m = (x < 0) ? 128'(-x) : 128'(x);
      m = (m + (128'd1 << (FB - 1))) >> FB;
      return (x < 0) ? -$signed(m) : $signed(m);
   endfunction

   // Scale by the fraction, divide by |b|^2, truncate toward zero
   function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] x,
                                                           input logic [127:0] den);
      logic [127:0] m;
      m = (x < 0) ? 128'(-x) : 128'(x);
      m = (m << FB) / den;
      return (x < 0) ? -$signed(m) : $signed(m);
   endfunction

   function automatic cplx_result_type complex_result(input cplx_request_type r);
      logic signed [127:0] ar, ai, br, bi, re, im;
      logic [127:0]        den;
      cplx_result_type     res;
      ar = $signed(r.a_re);
      ai = $signed(r.a_im);
      br = $signed(r.b_re);
      bi = $signed(r.b_im);
      res = '0;
      case (r.opcode)
         OP_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         OP_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         OP_MUL: begin
            re = round_product(ar * br - ai * bi);
            im = round_product(ai * br + ar * bi);
         end
         default: begin
            den = 128'(br * br + bi * bi);
            if (den == 0) begin
               res.div_zero = 1'b1;
               return res;
            end
            re = scaled_quotient(ar * br + ai * bi, den);
            im = scaled_quotient(ai * br - ar * bi, den);
         end
      endcase
      res.res_re = clamp_q(re, res.overflow);
      res.res_im = clamp_q(im, res.overflow);
      return res;
   endfunction

   // Receiver: pick ready at each falling edge
   always @(negedge clock) begin
      if (reset || rsp_hold)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin
      cplx_result_type got;
      cplx_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_res_re, rsp_res_im, rsp_overflow, rsp_div_zero};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat re=%h im=%h ov=%b dz=%b",
                        got.res_re, got.res_im, got.overflow, got.div_zero);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want re=%h im=%h ov=%b dz=%b, got re=%h im=%h ov=%b dz=%b",
                           want.res_re, want.res_im, want.overflow, want.div_zero,
                           got.res_re, got.res_im, got.overflow, got.div_zero);
            end
         end
      end
   end

   // Offer one request beat, idling first as the current ratio asks;
   // valid stays up after the beat until the next call or a drain drops it
   task automatic send_request(input cplx_request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= r.opcode;
      req_a_re   <= r.a_re;
      req_a_im   <= r.a_im;
      req_b_re   <= r.b_re;
      req_b_im   <= r.b_im;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(complex_result(r));
      @(negedge clock);
   endtask

   task automatic send_ops(input opcode_type op, input logic [DW-1:0] ar,
                           input logic [DW-1:0] ai, input logic [DW-1:0] br,
                           input logic [DW-1:0] bi);
      send_request(cplx_request_type'{op, ar, ai, br, bi});
   endtask

   function automatic logic [DW-1:0] random_operand();
      case ($urandom_range(5))
         0: return DW'($signed($urandom_range(8 << FB)) - (4 << FB));
         1: return {1'b0, {(DW-1){1'b1}}} ^ DW'($urandom_range(3));
         2: return {1'b1, {(DW-1){1'b0}}} | DW'($urandom_range(3));
         3: return DW'($signed($urandom_range(64)) - 32);
         default: return $urandom;
      endcase
   endfunction

   function automatic cplx_request_type random_request();
      cplx_request_type r;
      r.opcode = opcode_type'($urandom_range(3));
      r.a_re = random_operand();
      r.a_im = random_operand();
      r.b_re = random_operand();
      r.b_im = random_operand();
      // Zero divisors now and then
      if ($urandom_range(15) == 0) begin
         r.b_re = '0;
         r.b_im = '0;
      end
      return r;
   endfunction

   // Drop valid and wait for every outstanding result
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic test_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   endtask

   // Extremes, every operation, rounding ties and divide by zero
   task automatic test_directed();
      logic [DW-1:0] mx, mn, one, half;
      mx   = {1'b0, {(DW-1){1'b1}}};
      mn   = {1'b1, {(DW-1){1'b0}}};
      one  = DW'(1) << FB;
      half = DW'(1) << (FB - 1);
      send_ops(OP_ADD, mx, mn, mx, mn);
      send_ops(OP_ADD, mx, mn, mn, mx);
      send_ops(OP_SUB, mn, mx, mx, mn);
      send_ops(OP_SUB, '0, '0, mn, mn);
      send_ops(OP_MUL, mx, mx, mx, mn);
      send_ops(OP_MUL, mn, mn, mn, mn);
      send_ops(OP_MUL, DW'(1), '0, half, '0);
      send_ops(OP_MUL, -DW'(1), '0, half, '0);
      send_ops(OP_MUL, DW'(3), DW'(1), half, half);
      send_ops(OP_MUL, one, one, one, -one);
      send_ops(OP_DIV, one, one, '0, '0);
      send_ops(OP_DIV, '0, '0, '0, '0);
      send_ops(OP_DIV, mx, mn, DW'(1), '0);
      send_ops(OP_DIV, mn, mn, mn, mn);
      send_ops(OP_DIV, one, '0, DW'(3) << FB, '0);
      send_ops(OP_DIV, -one, '0, DW'(3) << FB, '0);
      send_ops(OP_DIV, one, one, one, -one);
      send_ops(OP_DIV, DW'(7), -DW'(5), mx, mx);
      send_ops(OP_ADD, '1, '1, '1, '1);
      send_ops(OP_SUB, '0, '0, '0, '0);
      wait_drained();
   endtask

   task automatic test_random(input int idle_pct, input int stall_pct, input int count);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_request(random_request());
   endtask

   // Hold the receiver off long enough to fill the pipe and stall the input
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fork
         begin
            rsp_hold = 1'b1;
            repeat (3 * LATENCY) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      repeat (LATENCY + 100) send_request(random_request());
      wait_drained();
   endtask

   initial begin
      test_reset();
      test_directed();
      test_random(0, 0, 300);
      test_random(60, 0, 300);
      wait_drained();
      test_random(0, 60, 300);
      test_random(27, 27, 300);
      test_backpressure();
      test_random(0, 0, 100);
      wait_drained();
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("PASS complex_arithmetic_unit_core");
      else
         $display("FAIL complex_arithmetic_unit_core");
      $finish;
   end

endmodule
